>>> rtl/swik_pkg.sv
// swik_pkg: shared constants, types and helper functions for the swerve inverse kinematics block
// depends on nothing; imported by swerve_inverse_kinematics and its checker
`default_nettype none

package swik_pkg;

	localparam int NUM_MODULES         = 4;
	localparam int ANGLE_FRAC_BITS_DEF = 14;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int TABLE_LEN           = 24;

	// payload widths
	localparam int IN_W    = 128;
	localparam int OUT_W   = 176;
	localparam int VEL_W   = 16;
	localparam int ANG_W   = 20;
	localparam int RATE_W  = 24;
	localparam int CFG_W   = 16;

	// internal datapath widths
	localparam int XW = 36;
	localparam int ZW = 36;
	localparam int CW = 42;
	localparam int DW = 35;

	// angles in Q.30 radians
	localparam logic signed [CW-1:0] Q_PI      = 42'sd3373259426;
	localparam logic signed [CW-1:0] Q_TWO_PI  = 42'sd6746518852;
	localparam logic signed [CW-1:0] Q_HALF_PI = 42'sd1686629713;
	localparam logic [29:0]          CORDIC_INV_GAIN = 30'd652032874;
	localparam logic [33:0]          SPEED_FLOOR     = 34'd34;

	typedef logic [1:0] corner_t;
	localparam corner_t CORNER_FL = 2'd0;
	localparam corner_t CORNER_FR = 2'd1;
	localparam corner_t CORNER_RL = 2'd2;
	localparam corner_t CORNER_RR = 2'd3;

	typedef enum logic [1:0] {
		REG_WHEELBASE   = 2'd0,
		REG_TRACK_WIDTH = 2'd1,
		REG_INV_RADIUS  = 2'd2,
		REG_FLIP        = 2'd3
	} cfg_reg_t;

	// arctan(2^-i) in Q.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314857;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043837;
			5'd3:  r = 30'd133525159;
			5'd4:  r = 30'd67021687;
			5'd5:  r = 30'd33543516;
			5'd6:  r = 30'd16775851;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194283;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048576;
			5'd11: r = 30'd524288;
			5'd12: r = 30'd262144;
			5'd13: r = 30'd131072;
			5'd14: r = 30'd65536;
			5'd15: r = 30'd32768;
			5'd16: r = 30'd16384;
			5'd17: r = 30'd8192;
			5'd18: r = 30'd4096;
			5'd19: r = 30'd2048;
			5'd20: r = 30'd1024;
			5'd21: r = 30'd512;
			5'd22: r = 30'd256;
			5'd23: r = 30'd128;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// clamp a 22-bit signed angle to the 20-bit field
	function automatic logic [ANG_W-1:0] sat_angle(input logic signed [21:0] v);
		logic [ANG_W-1:0] r;
		if (v > 22'sd524287)
			r = 20'h7FFFF;
		else if (v < -22'sd524288)
			r = 20'h80000;
		else
			r = v[ANG_W-1:0];
		return r;
	endfunction

	// clamp a 27-bit signed rate to the 24-bit field
	function automatic logic [RATE_W-1:0] sat_rate(input logic signed [26:0] v);
		logic [RATE_W-1:0] r;
		if (v > 27'sd8388607)
			r = 24'h7FFFFF;
		else if (v < -27'sd8388608)
			r = 24'h800000;
		else
			r = v[RATE_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/swerve_inverse_kinematics.sv
// swerve_inverse_kinematics: body velocity to per-corner steering angle and wheel rate
// depends on swik_pkg (constants, arctan table, saturation helpers)
//
//  channel   | dir | handshake                 | word
//  s_axis    | in  | s_axis_tvalid/tready      | vx, vy, yaw, four present angles
//  m_axis    | out | m_axis_tvalid/tready      | four steer commands, four wheel rates
//  cfg       | in  | cfg_valid/cfg_ready       | register index, 16-bit data
//
// one shared pipelined cordic path takes one corner per cycle while the
// output is not stalled; a new word is taken when the sequencer is idle
// or its last corner issues. reset clears config to defaults and empties
// the pipeline. a stalled output freezes the whole pipeline; nothing is dropped.
`default_nettype none

module swerve_inverse_kinematics
	import swik_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// vx[15:0] vy[31:16] yaw[47:32] fl[67:48] fr[87:68] rl[107:88] rr[127:108]
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// steer fl,fr,rl,rr [79:0] (20 each), rate fl,fr,rl,rr [175:80] (24 each)
	output logic [OUT_W-1:0]      m_axis_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int SH = 30 - ANGLE_FRAC_BITS;
	localparam int N  = CORDIC_STEPS;
	localparam logic signed [CW-1:0] C_BIAS  = Q_TWO_PI <<< 7;
	localparam logic signed [CW-1:0] FOUR_PI = Q_TWO_PI <<< 1;
	localparam logic signed [DW-1:0] PI_D      = Q_PI[DW-1:0];
	localparam logic signed [DW-1:0] TWO_PI_D  = Q_TWO_PI[DW-1:0];
	localparam logic signed [DW-1:0] HALF_PI_D = Q_HALF_PI[DW-1:0];
	localparam logic signed [DW-1:0] RND_D     = DW'(1) <<< (SH - 1);

	// configuration registers
	logic [CFG_W-1:0] wheelbase_q, track_width_q, inv_radius_q;
	logic             flip_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q   <= 16'd4096;
			track_width_q <= 16'd4096;
			inv_radius_q  <= 16'd2560;
			flip_q        <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WHEELBASE:   wheelbase_q   <= cfg_data;
				REG_TRACK_WIDTH: track_width_q <= cfg_data;
				REG_INV_RADIUS:  inv_radius_q  <= cfg_data;
				REG_FLIP:        flip_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: output slot free or being taken
	logic en;
	logic m_valid_q;
	assign en = !m_valid_q || m_axis_tready;

	// input hold register and corner sequencer
	logic            in_valid_q;
	logic [IN_W-1:0] in_data_q;
	corner_t         cnt_q;
	logic            issue;

	assign issue         = in_valid_q && en;
	assign s_axis_tready = !in_valid_q || (en && cnt_q == CORNER_RR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q <= 1'b0;
			cnt_q      <= CORNER_FL;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_q <= 1'b1;
			cnt_q      <= CORNER_FL;
		end else if (issue) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == CORNER_RR)
				in_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			in_data_q <= s_axis_tdata;
	end

	// field extraction
	logic signed [VEL_W-1:0] vx_w, vy_w, wz_w;
	logic signed [ANG_W-1:0] cur_w;
	assign vx_w = in_data_q[15:0];
	assign vy_w = in_data_q[31:16];
	assign wz_w = in_data_q[47:32];
	always_comb begin
		case (cnt_q)
			CORNER_FL: cur_w = in_data_q[67:48];
			CORNER_FR: cur_w = in_data_q[87:68];
			CORNER_RL: cur_w = in_data_q[107:88];
			CORNER_RR: cur_w = in_data_q[127:108];
			default:   cur_w = in_data_q[67:48];
		endcase
	end

	// stage 1: yaw products
	logic                    v_s1;
	logic signed [VEL_W-1:0] vx_s1, vy_s1;
	logic signed [32:0]      pt_s1, pw_s1;
	logic signed [ANG_W-1:0] cur_s1;
	corner_t                 idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1  <= vx_w;
			vy_s1  <= vy_w;
			pt_s1  <= wz_w * $signed({1'b0, track_width_q});
			pw_s1  <= wz_w * $signed({1'b0, wheelbase_q});
			cur_s1 <= cur_w;
			idx_s1 <= cnt_q;
		end
	end

	// cordic pipeline arrays, entry 0 is the stage 2 output
	logic                    cv   [0:N];
	logic signed [XW-1:0]    cx   [0:N];
	logic signed [XW-1:0]    cy   [0:N];
	logic signed [ZW-1:0]    cz   [0:N];
	logic signed [CW-1:0]    cc   [0:N];
	logic signed [ANG_W-1:0] ccur [0:N];
	corner_t                 cidx [0:N];

	// stage 2: module velocity, half-plane pre-rotation, angle bias
	logic signed [XW-1:0] mx_w, my_w, vx8_w, vy8_w, pt_w, pw_w;
	logic signed [CW-1:0] c_w;
	assign vx8_w = XW'(vx_s1) <<< 13;
	assign vy8_w = XW'(vy_s1) <<< 13;
	assign pt_w  = XW'(pt_s1);
	assign pw_w  = XW'(pw_s1);
	assign mx_w  = idx_s1[0] ? vx8_w + pt_w : vx8_w - pt_w;
	assign my_w  = idx_s1[1] ? vy8_w - pw_w : vy8_w + pw_w;
	assign c_w   = (CW'(cur_s1) <<< SH) + C_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv[0] <= 1'b0;
		else if (en)
			cv[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mx_w < 0) begin
				cx[0] <= -mx_w;
				cy[0] <= -my_w;
				cz[0] <= (my_w >= 0) ? Q_PI[ZW-1:0] : -Q_PI[ZW-1:0];
			end else begin
				cx[0] <= mx_w;
				cy[0] <= my_w;
				cz[0] <= '0;
			end
			cc[0]   <= c_w;
			ccur[0] <= cur_s1;
			cidx[0] <= idx_s1;
		end
	end

	// cordic iterations, one per stage; first eight also reduce the present angle mod 2pi
	for (genvar k = 0; k < N; k++) begin : g_cordic
		localparam logic [4:0] KI = 5'(k);
		localparam int RK = (k < 8) ? 7 - k : 0;
		localparam logic RED_EN = (k < 8);
		localparam logic signed [CW-1:0] RSTEP = Q_TWO_PI <<< RK;
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] at;
		assign xs = cx[k] >>> k;
		assign ys = cy[k] >>> k;
		assign at = $signed({{(ZW-30){1'b0}}, atan_q30(KI)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv[k+1] <= 1'b0;
			else if (en)
				cv[k+1] <= cv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cy[k] >= 0) begin
					cx[k+1] <= cx[k] + ys;
					cy[k+1] <= cy[k] - xs;
					cz[k+1] <= cz[k] + at;
				end else begin
					cx[k+1] <= cx[k] - ys;
					cy[k+1] <= cy[k] + xs;
					cz[k+1] <= cz[k] - at;
				end
				if (RED_EN && cc[k] >= RSTEP)
					cc[k+1] <= cc[k] - RSTEP;
				else
					cc[k+1] <= cc[k];
				ccur[k+1] <= ccur[k];
				cidx[k+1] <= cidx[k];
			end
		end
	end

	// post 1: gain correction partial products, raw angle difference
	logic                    v_p1;
	logic [46:0]             plo_p1;
	logic [48:0]             phi_p1;
	logic signed [CW-1:0]    d_p1;
	logic signed [ANG_W-1:0] cur_p1;
	corner_t                 idx_p1;
	logic [16:0]             rlo_w;
	logic [18:0]             rhi_w;
	assign rlo_w = cx[N][16:0];
	assign rhi_w = cx[N][XW-1:17];

	// post 2: speed, difference brought into [0, 2pi)
	logic                    v_p2;
	logic [33:0]             spd_p2;
	logic signed [DW-1:0]    d_p2;
	logic signed [ANG_W-1:0] cur_p2;
	corner_t                 idx_p2;
	logic [65:0]             msum_w;
	logic signed [CW-1:0]    d1_w, d2_w;
	assign msum_w = {phi_p1, 17'b0} + 66'(plo_p1);
	assign d1_w   = (d_p1 >= FOUR_PI) ? d_p1 - FOUR_PI : d_p1;
	assign d2_w   = (d1_w >= Q_TWO_PI) ? d1_w - Q_TWO_PI : d1_w;

	// post 3: wrap, quarter-turn flip, rate product
	logic                    v_p3;
	logic signed [DW-1:0]    w_p3;
	logic                    rev_p3, stand_p3;
	logic [49:0]             prod_p3;
	logic signed [ANG_W-1:0] cur_p3;
	corner_t                 idx_p3;
	logic signed [DW-1:0]    w_w, wf_w, wf2_w;
	logic                    flip_w;
	assign w_w    = (d_p2 > PI_D) ? d_p2 - TWO_PI_D : d_p2;
	assign flip_w = flip_q && (w_w > HALF_PI_D || w_w < -HALF_PI_D);
	assign wf_w   = w_w + PI_D;
	assign wf2_w  = (wf_w > PI_D) ? wf_w - TWO_PI_D : wf_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= cv[N];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_p1   <= rlo_w * CORDIC_INV_GAIN;
			phi_p1   <= rhi_w * CORDIC_INV_GAIN;
			d_p1     <= CW'(cz[N]) - cc[N] + FOUR_PI;
			cur_p1   <= ccur[N];
			idx_p1   <= cidx[N];

			spd_p2   <= msum_w[63:30];
			d_p2     <= d2_w[DW-1:0];
			cur_p2   <= cur_p1;
			idx_p2   <= idx_p1;

			w_p3     <= flip_w ? wf2_w : w_w;
			rev_p3   <= flip_w;
			stand_p3 <= spd_p2 < SPEED_FLOOR;
			prod_p3  <= spd_p2 * inv_radius_q;
			cur_p3   <= cur_p2;
			idx_p3   <= idx_p2;
		end
	end

	// final: round, sign, saturate, collect corners into the output word
	logic signed [DW-1:0]     wr_w;
	logic signed [21:0]       steer_w;
	logic [25:0]              rmag_w;
	logic signed [26:0]       rate_w;
	logic [ANG_W-1:0]         steer_f;
	logic [RATE_W-1:0]        rate_f;
	logic [ANG_W-1:0]         steer_col_q [0:2];
	logic [RATE_W-1:0]        rate_col_q  [0:2];
	logic [OUT_W-1:0]         out_q;

	assign wr_w    = (w_p3 + RND_D) >>> SH;
	assign steer_w = 22'(cur_p3) + 22'(wr_w);
	assign rmag_w  = 26'((prod_p3 + 50'd16777216) >> 25);
	assign rate_w  = rev_p3 ? -$signed({1'b0, rmag_w}) : $signed({1'b0, rmag_w});
	assign steer_f = stand_p3 ? cur_p3 : sat_angle(steer_w);
	assign rate_f  = stand_p3 ? '0 : sat_rate(rate_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (en)
			m_valid_q <= v_p3 && idx_p3 == CORNER_RR;
	end

	always_ff @(posedge clk) begin
		if (en && v_p3) begin
			case (idx_p3)
				CORNER_FL: begin
					steer_col_q[0] <= steer_f;
					rate_col_q[0]  <= rate_f;
				end
				CORNER_FR: begin
					steer_col_q[1] <= steer_f;
					rate_col_q[1]  <= rate_f;
				end
				CORNER_RL: begin
					steer_col_q[2] <= steer_f;
					rate_col_q[2]  <= rate_f;
				end
				CORNER_RR: begin
					out_q <= {rate_f, rate_col_q[2], rate_col_q[1], rate_col_q[0],
						steer_f, steer_col_q[2], steer_col_q[1], steer_col_q[0]};
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

>>> rtl/swik_checker.sv
// swik_assert: port-level assertions for swerve_inverse_kinematics
// depends on swik_pkg; bound to the top level at the end of this file
`default_nettype none

module swik_assert
	import swik_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// the four corners share the path, so input stays blocked while the first three issue
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready
			##1 !s_axis_tready)
		else $error("input taken before previous word left the sequencer");

	// config writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config port not ready");

endmodule

bind swerve_inverse_kinematics swik_assert u_swik_assert (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);

`default_nettype wire

>>> verif/swik_checker.sv
// swik_checker: watches the command, result and config channels of the swerve kinematics block,
// computes the expected steering and wheel rate word for every accepted command and compares
// depends on swik_pkg for widths and register codes
`timescale 1ns / 1ps
`default_nettype none

module swik_checker
	import swik_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	input  wire logic             s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	input  wire logic             m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire logic [OUT_W-1:0] m_axis_tdata,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending,
	output int                    results_seen
);

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_COMP   = 64'sd652032874;
	localparam longint STILL_LIMIT = 64'sd34;
	localparam int     STEPS       = CORDIC_STEPS_DEF;
	localparam int     ASHIFT      = 30 - ANGLE_FRAC_BITS_DEF;

	// arctan(2^-i), Q.30 radians
	localparam longint ATAN_LUT [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128
	};

	logic [15:0] wheelbase_q;
	logic [15:0] track_q;
	logic [15:0] inv_radius_q;
	logic        flip_en;

	logic [OUT_W-1:0] expected_words[$];

	function automatic longint wrap_pi(input longint d);
		longint r;
		r = d % TWO_PI_Q30;
		if (r < 0) r += TWO_PI_Q30;
		if (r > PI_Q30) r -= TWO_PI_Q30;
		return r;
	endfunction

	function automatic longint clamp_to(input longint v, input int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// per-corner steering command and wheel rate for one command word
	function automatic logic [OUT_W-1:0] steer_rate_solve(input logic [IN_W-1:0] w);
		longint vx, vy, wz, cur, mx, my, x, y, z, xs, ys, spd, d, steer, rate;
		longint px, py;
		logic rev;
		logic [OUT_W-1:0] r;
		vx = longint'($signed(w[15:0]));
		vy = longint'($signed(w[31:16]));
		wz = longint'($signed(w[47:32]));
		r = '0;
		for (int m = 0; m < NUM_MODULES; m++) begin
			cur = longint'($signed(w[48 + 20 * m +: 20]));
			px = (m < 2) ? 1 : -1;
			py = (m % 2 == 0) ? 1 : -1;
			mx = vx * 8192 - py * (wz * longint'(track_q));
			my = vy * 8192 + px * (wz * longint'(wheelbase_q));
			// vectoring rotation, left half plane folded first
			x = mx;
			y = my;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? PI_Q30 : -PI_Q30;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys;
					y -= xs;
					z += ATAN_LUT[i];
				end else begin
					x -= ys;
					y += xs;
					z -= ATAN_LUT[i];
				end
			end
			spd = (x * GAIN_COMP) >>> 30;
			rev = 1'b0;
			if (spd < STILL_LIMIT) begin
				steer = cur;
				rate = 0;
			end else begin
				d = wrap_pi(z - (cur <<< ASHIFT));
				if (flip_en && (d > HALF_PI_Q30 || d < -HALF_PI_Q30)) begin
					d = wrap_pi(d + PI_Q30);
					rev = 1'b1;
				end
				steer = cur + ((d + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT);
				rate = (spd * longint'(inv_radius_q) + (64'sd1 <<< 24)) >>> 25;
				if (rev) rate = -rate;
			end
			r[20 * m +: 20] = 20'(clamp_to(steer, ANG_W));
			r[80 + 24 * m +: 24] = 24'(clamp_to(rate, RATE_W));
		end
		return r;
	endfunction

	task automatic report(input string what, input int corner, input longint got,
			input longint want);
		if (fails < 30)
			$display("%0t mismatch %s corner %0d: got %0d, want %0d", $realtime, what, corner,
				got, want);
		fails++;
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		if (!arst_n) begin
			wheelbase_q <= 16'd4096;
			track_q <= 16'd4096;
			inv_radius_q <= 16'd2560;
			flip_en <= 1'b1;
			expected_words.delete();
			fails = 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (expected_words.size() == 0) begin
					if (fails < 30) $display("%0t result word with nothing expected", $realtime);
					fails++;
				end else begin
					want = expected_words.pop_front();
					for (int m = 0; m < NUM_MODULES; m++) begin
						if (m_axis_tdata[20 * m +: 20] != want[20 * m +: 20])
							report("steer", m, $signed(m_axis_tdata[20 * m +: 20]),
								$signed(want[20 * m +: 20]));
						if (m_axis_tdata[80 + 24 * m +: 24] != want[80 + 24 * m +: 24])
							report("wheel rate", m, $signed(m_axis_tdata[80 + 24 * m +: 24]),
								$signed(want[80 + 24 * m +: 24]));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(steer_rate_solve(s_axis_tdata));
			pending <= expected_words.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_WHEELBASE:   wheelbase_q <= cfg_data;
					REG_TRACK_WIDTH: track_q <= cfg_data;
					REG_INV_RADIUS:  inv_radius_q <= cfg_data;
					REG_FLIP:        flip_en <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// tb_top: drives commands, result back-pressure and config phases into swerve_inverse_kinematics
// depends on swik_pkg and swik_checker, which predicts and compares every result word
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import swik_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;
	localparam int PHASE_ITEMS = 190;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// vx[15:0] vy[31:16] yaw[47:32] fl[67:48] fr[87:68] rl[107:88] rr[127:108]
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// steer fl,fr,rl,rr [79:0], rate fl,fr,rl,rr [175:80]
	logic [OUT_W-1:0] m_axis_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fails;
	int pending;
	int results_seen;
	int words_sent;
	int burst_left;
	bit long_hold_done;

	swerve_inverse_kinematics uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	swik_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stall patterns, one long hold once traffic is flowing
	initial begin
		int mode;
		int left;
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && results_seen >= 100) begin
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(5, 80);
			end
			left--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (left % 3 != 0);
			endcase
		end
	end

	function automatic logic [IN_W-1:0] pack_cmd(input logic [15:0] vx, input logic [15:0] vy,
			input logic [15:0] wz, input logic [19:0] a0, input logic [19:0] a1,
			input logic [19:0] a2, input logic [19:0] a3);
		return {a3, a2, a1, a0, wz, vy, vx};
	endfunction

	// offer one command word, then maybe a gap when the burst runs out
	task automatic send_cmd(input logic [IN_W-1:0] w);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// config valid stays up across back-to-back writes; the caller drops it
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// let the last accepted word reach the checker first so the pending count includes it
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [15:0] wb, input logic [15:0] tw,
			input logic [15:0] ir, input logic fl);
		drain();
		write_reg(REG_WHEELBASE, wb);
		write_reg(REG_TRACK_WIDTH, tw);
		write_reg(REG_INV_RADIUS, ir);
		write_reg(REG_FLIP, {15'd0, fl});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random command, biased toward realistic motion, near-standing commands and angles near a quarter turn
	task automatic send_random;
		logic [15:0] v[3];
		logic [19:0] a[4];
		int kind;
		kind = $urandom_range(0, 9);
		foreach (v[i]) v[i] = 16'($urandom);
		foreach (a[i]) a[i] = 20'($urandom);
		if (kind < 4) begin
			foreach (v[i]) v[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
			foreach (a[i]) a[i] = 20'($signed($urandom_range(0, 120000)) - 60000);
		end else if (kind == 4) begin
			v[0] = 16'd0;
			v[1] = 16'd0;
			v[2] = $urandom_range(0, 1) ? 16'd0 : 16'($signed($urandom_range(0, 4)) - 2);
		end else if (kind == 5) begin
			foreach (a[i]) a[i] = 20'($signed($urandom_range(0, 2000)) - 1000
				+ ($urandom_range(0, 1) ? 25736 : -25736));
		end
		send_cmd(pack_cmd(v[0], v[1], v[2], a[0], a[1], a[2], a[3]));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WHEELBASE;
		cfg_data = '0;
		words_sent = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset geometry
		send_cmd(pack_cmd(16'd0, 16'd0, 16'd0, 20'h80000, 20'h7FFFF, 20'd0, 20'hFFFFF));
		send_cmd(pack_cmd(16'h7FFF, 16'd0, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'h8000, 16'd0, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd0, 16'h7FFF, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd0, 16'h8000, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd0, 16'd0, 16'h7FFF, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd0, 16'd0, 16'h8000, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 20'h7FFFF, 20'h80000, 20'h7FFFF,
			20'h80000));
		send_cmd(pack_cmd(16'h8000, 16'h8000, 16'h8000, 20'h80000, 20'h7FFFF, 20'h80000,
			20'h7FFFF));
		// around a quarter turn from the heading
		send_cmd(pack_cmd(16'd4096, 16'd0, 16'd0, 20'd25735, 20'd25737, -20'sd25735,
			-20'sd25737));
		send_cmd(pack_cmd(16'd4096, 16'd0, 16'd0, 20'd25736, -20'sd25736, 20'd51472,
			-20'sd51472));
		// heading near pi against angles on both sides of the wrap
		send_cmd(pack_cmd(16'hF000, 16'd1, 16'd0, 20'd51472, -20'sd51472, 20'd0, 20'd102944));
		send_cmd(pack_cmd(16'hF000, 16'hFFFF, 16'd0, 20'd51472, -20'sd51472, 20'd0,
			-20'sd102944));
		// tiny motion and yaw cancelling the forward term on one side
		send_cmd(pack_cmd(16'd1, 16'hFFFF, 16'd0, 20'd0, 20'd100, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd1, 16'd0, 16'd2, 20'd0, 20'd0, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'd0, 16'd0, 16'd1, 20'h7FFFF, 20'h80000, 20'd0, 20'd0));
		send_cmd(pack_cmd(16'h5555, 16'hAAAA, 16'h5555, 20'hAAAAA, 20'h55555, 20'hAAAAA,
			20'h55555));

		// random phases over several geometries
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: set_geometry(16'd0, 16'd0, 16'd1, 1'b0);
				2: set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
				3: set_geometry(16'd4096, 16'd2048, 16'd0, 1'b1);
				4: set_geometry(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
					1'b0);
				5: set_geometry(16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
				default: set_geometry(16'($urandom_range(0, 8192)),
					16'($urandom_range(0, 8192)), 16'($urandom_range(1, 4096)), 1'b1);
			endcase
			repeat (PHASE_ITEMS) send_random();
		end

		drain();
		$display("sent %0d command words over 7 geometry settings, checked %0d result words",
			words_sent, results_seen);
		$display("covered standing, flipped, wrapped and saturated corners plus a long stall");
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/swik_pkg.sv
rtl/swerve_inverse_kinematics.sv
rtl/swik_checker.sv
verif/swik_checker.sv
verif/tb_top.sv
